// ----- rtl/core/isru_pkg.sv -----
// Shared types, codes and constants of the interrupt and special register unit.
package isru_pkg;

    localparam int IRQ_LINES     = 32;
    localparam int SCRATCH_COUNT = 7;
    localparam int LEVELS        = 3;

    localparam int LEVEL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SCRATCH_W = (SCRATCH_COUNT > 1) ? $clog2(SCRATCH_COUNT) : 1;
    localparam int PS_W      = 15;

    localparam int IN_TDATA_W  = 128;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_TUSER_W = 2;

    // Event codes
    typedef enum logic [2:0] {
        OP_RAISE    = 3'd0,
        OP_CLEAR    = 3'd1,
        OP_SR_READ  = 3'd2,
        OP_SR_WRITE = 3'd3,
        OP_RFI      = 3'd4,
        OP_LOOP     = 3'd5,
        OP_RETIRE   = 3'd6
    } isru_op_e;

    // Special register numbers
    localparam logic [7:0] SR_LBEG        = 8'd0;
    localparam logic [7:0] SR_LEND        = 8'd1;
    localparam logic [7:0] SR_LCOUNT      = 8'd2;
    localparam logic [7:0] SR_SAR         = 8'd3;
    localparam logic [7:0] SR_LITBASE     = 8'd5;
    localparam logic [7:0] SR_WINDOWBASE  = 8'd72;
    localparam logic [7:0] SR_WINDOWSTART = 8'd73;
    localparam logic [7:0] SR_EPC2        = 8'd178;
    localparam logic [7:0] SR_SCRATCH0    = 8'd209;
    localparam logic [7:0] SR_INTERRUPT   = 8'd226;
    localparam logic [7:0] SR_INTCLEAR    = 8'd227;
    localparam logic [7:0] SR_INTENABLE   = 8'd228;
    localparam logic [7:0] SR_PS          = 8'd230;

    // Interrupt vectors by level
    localparam logic [31:0] VEC_LEVEL1 = 32'h008E_0720;
    localparam logic [31:0] VEC_LEVEL2 = 32'h008E_0920;
    localparam logic [31:0] VEC_LEVEL3 = 32'h008E_0A20;
    localparam logic [4:0]  LAST_LEVEL2_LINE = 5'd14;

    // PS bit positions (compressed image keeps bits 11:0 in place)
    localparam int PS_EXC_BIT = 4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] current_pc;
        logic [4:0]  irq_id;
        logic [7:0]  sr_index;
        logic [31:0] write_value;
        logic signed [31:0] loop_count;
        logic [8:0]  loop_offset;
        logic        loop_run;
        logic [1:0]  rfi_level;
    } isru_item_t;

    typedef struct packed {
        logic [31:0] new_pc;
        logic        pc_redirect;
        logic [31:0] read_data;
        logic        wake;
    } isru_result_t;

    // 32-bit PS image from the 15 live bits
    function automatic logic [31:0] ps_expand(input logic [PS_W-1:0] ps);
        return {13'd0, ps[14:12], 4'd0, ps[11:0]};
    endfunction

    // 15 live bits from a 32-bit PS image
    function automatic logic [PS_W-1:0] ps_compress(input logic [31:0] v);
        return {v[18:16], v[11:0]};
    endfunction

endpackage

// ----- rtl/core/isru_core.sv -----
// Architectural state and single-step update of the interrupt and special register unit.
module isru_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  isru_pkg::isru_item_t  item,
    output isru_pkg::isru_result_t result
);
    import isru_pkg::*;

    logic [PS_W-1:0]      status_reg, status_next;
    logic [31:0]          saved_pc_reg [LEVELS];
    logic [31:0]          saved_pc_next [LEVELS];
    logic [PS_W-1:0]      saved_status_reg [LEVELS];
    logic [PS_W-1:0]      saved_status_next [LEVELS];
    logic [31:0]          scratch_reg [SCRATCH_COUNT];
    logic [31:0]          scratch_next [SCRATCH_COUNT];
    logic [31:0]          loop_begin_reg, loop_begin_next;
    logic [31:0]          loop_end_reg, loop_end_next;
    logic [31:0]          loop_remaining_reg, loop_remaining_next;
    logic [4:0]           shift_amount_reg, shift_amount_next;
    logic [31:0]          literal_base_reg, literal_base_next;
    logic [7:0]           window_base_reg, window_base_next;
    logic [31:0]          window_start_reg, window_start_next;
    logic [IRQ_LINES-1:0] pending_reg, pending_next;
    logic [IRQ_LINES-1:0] enabled_reg, enabled_next;

    logic                 line_ok;
    logic [IRQ_LINES-1:0] line_bit;
    logic [1:0]           raise_level;
    logic [31:0]          raise_vec;
    logic [LEVEL_W-1:0]   raise_idx;
    logic                 rfi_ok;
    logic [LEVEL_W-1:0]   rfi_idx;
    logic [7:0]           scratch_off;
    logic                 scratch_hit;
    logic [SCRATCH_W-1:0] scratch_idx;
    logic [31:0]          sr_rdata;
    logic [31:0]          new_loop_end;

    assign line_ok  = 32'(item.irq_id) < 32'(IRQ_LINES);
    assign line_bit = IRQ_LINES'(1) << item.irq_id;

    always_comb
    begin
        if (item.irq_id == 5'd0)
        begin
            raise_level = 2'd1;
            raise_vec   = VEC_LEVEL1;
        end
        else if (item.irq_id <= LAST_LEVEL2_LINE)
        begin
            raise_level = 2'd2;
            raise_vec   = VEC_LEVEL2;
        end
        else
        begin
            raise_level = 2'd3;
            raise_vec   = VEC_LEVEL3;
        end
    end

    assign raise_idx    = LEVEL_W'(raise_level - 2'd1);
    assign rfi_ok       = (item.rfi_level != 2'd0) && (32'(item.rfi_level) <= 32'(LEVELS));
    assign rfi_idx      = LEVEL_W'(item.rfi_level - 2'd1);
    assign scratch_off  = item.sr_index - SR_SCRATCH0;
    assign scratch_hit  = (item.sr_index >= SR_SCRATCH0)
                       && (32'(scratch_off) < 32'(SCRATCH_COUNT));
    assign scratch_idx  = scratch_off[SCRATCH_W-1:0];
    assign new_loop_end = item.current_pc + 32'(item.loop_offset) + 32'd1;

    // Special register read mux
    always_comb
    begin
        unique case (item.sr_index)
            SR_LBEG:      sr_rdata = loop_begin_reg;
            SR_LEND:      sr_rdata = loop_end_reg;
            SR_LCOUNT:    sr_rdata = loop_remaining_reg;
            SR_SAR:       sr_rdata = 32'(shift_amount_reg);
            SR_EPC2:      sr_rdata = (LEVELS > 1) ? saved_pc_reg[LEVEL_W'(1)] : 32'd0;
            SR_INTERRUPT: sr_rdata = 32'(pending_reg);
            SR_INTENABLE: sr_rdata = 32'(enabled_reg);
            SR_PS:        sr_rdata = ps_expand(status_reg);
            default:      sr_rdata = scratch_hit ? scratch_reg[scratch_idx] : 32'd0;
        endcase
    end

    always_comb
    begin
        status_next         = status_reg;
        saved_pc_next       = saved_pc_reg;
        saved_status_next   = saved_status_reg;
        scratch_next        = scratch_reg;
        loop_begin_next     = loop_begin_reg;
        loop_end_next       = loop_end_reg;
        loop_remaining_next = loop_remaining_reg;
        shift_amount_next   = shift_amount_reg;
        literal_base_next   = literal_base_reg;
        window_base_next    = window_base_reg;
        window_start_next   = window_start_reg;
        pending_next        = pending_reg;
        enabled_next        = enabled_reg;
        result              = '0;

        unique case (item.opcode)
            OP_RAISE:
            begin
                if (line_ok)
                begin
                    pending_next = pending_reg | line_bit;
                    if (((enabled_reg & line_bit) != '0)
                        && (status_reg[3:0] < {2'b00, raise_level}))
                    begin
                        saved_pc_next[raise_idx]     = item.current_pc;
                        saved_status_next[raise_idx] = status_reg;
                        status_next[3:0]             = {2'b00, raise_level};
                        status_next[PS_EXC_BIT]      = 1'b1;
                        result.new_pc                = raise_vec;
                        result.pc_redirect           = 1'b1;
                        result.wake                  = 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                if (line_ok)
                begin
                    pending_next = pending_reg & ~line_bit;
                end
            end
            OP_SR_READ:
            begin
                result.read_data = sr_rdata;
            end
            OP_SR_WRITE:
            begin
                unique case (item.sr_index)
                    SR_LBEG:        loop_begin_next     = item.write_value;
                    SR_LEND:        loop_end_next       = item.write_value;
                    SR_LCOUNT:      loop_remaining_next = item.write_value;
                    SR_SAR:         shift_amount_next   = item.write_value[4:0];
                    SR_LITBASE:     literal_base_next   = item.write_value;
                    SR_WINDOWBASE:  window_base_next    = item.write_value[7:0];
                    SR_WINDOWSTART: window_start_next   = item.write_value;
                    SR_INTCLEAR:    pending_next = pending_reg & ~item.write_value[IRQ_LINES-1:0];
                    SR_INTENABLE:   enabled_next = item.write_value[IRQ_LINES-1:0];
                    SR_PS:          status_next  = ps_compress(item.write_value);
                    default:
                    begin
                        if (scratch_hit)
                        begin
                            scratch_next[scratch_idx] = item.write_value;
                        end
                    end
                endcase
            end
            OP_RFI:
            begin
                if (rfi_ok)
                begin
                    result.new_pc      = saved_pc_reg[rfi_idx];
                    result.pc_redirect = 1'b1;
                    status_next        = saved_status_reg[rfi_idx];
                end
            end
            OP_LOOP:
            begin
                loop_remaining_next = (!item.loop_count[31] && (item.loop_count != '0))
                                    ? 32'(item.loop_count) - 32'd1 : 32'd0;
                loop_begin_next     = item.current_pc;
                loop_end_next       = new_loop_end;
                if (!item.loop_run)
                begin
                    result.new_pc      = new_loop_end;
                    result.pc_redirect = 1'b1;
                end
            end
            OP_RETIRE:
            begin
                if ((loop_remaining_reg != 32'd0) && (item.current_pc == loop_end_reg)
                    && !status_reg[PS_EXC_BIT])
                begin
                    result.new_pc       = loop_begin_reg;
                    result.pc_redirect  = 1'b1;
                    loop_remaining_next = loop_remaining_reg - 32'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg         <= '0;
            saved_pc_reg       <= '{default: '0};
            saved_status_reg   <= '{default: '0};
            scratch_reg        <= '{default: '0};
            loop_begin_reg     <= '0;
            loop_end_reg       <= '0;
            loop_remaining_reg <= '0;
            shift_amount_reg   <= '0;
            literal_base_reg   <= '0;
            window_base_reg    <= '0;
            window_start_reg   <= '0;
            pending_reg        <= '0;
            enabled_reg        <= '0;
        end
        else if (step_en)
        begin
            status_reg         <= status_next;
            saved_pc_reg       <= saved_pc_next;
            saved_status_reg   <= saved_status_next;
            scratch_reg        <= scratch_next;
            loop_begin_reg     <= loop_begin_next;
            loop_end_reg       <= loop_end_next;
            loop_remaining_reg <= loop_remaining_next;
            shift_amount_reg   <= shift_amount_next;
            literal_base_reg   <= literal_base_next;
            window_base_reg    <= window_base_next;
            window_start_reg   <= window_start_next;
            pending_reg        <= pending_next;
            enabled_reg        <= enabled_next;
        end
    end

endmodule

// ----- rtl/core/interrupt_and_special_register_unit.sv -----
// Top level of the interrupt, special register and zero-overhead-loop unit.
//
// Usage:
//   s_axis carries one request per core event. tuser holds the opcode (raise,
//   clear, SR read, SR write, rfi, loop setup, retire); tdata holds the operands.
//   m_axis returns exactly one result per request, in order: tdata holds
//   new_pc and read_data, tuser holds pc_redirect and wake.
//
// Timing:
//   A request is held in the input register, where the step logic reads the
//   state and computes the result; the result register is loaded when the
//   held request advances. Throughput is one request per cycle while
//   m_axis_tready stays high: both registers advance together and the
//   state update is a single pass of compares and muxes.
//
// Reset: all special registers, saved pc/status, pending and enable masks
//   clear; both pipeline registers go empty and s_axis_tready rises.
// Stall: when m_axis_tready is low with a result held, the input register
//   holds its request and s_axis_tready drops once that register is full;
//   no state update happens until the result is taken.
module interrupt_and_special_register_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // current_pc[31:0], irq_id[36:32], sr_index[44:37], write_value[76:45],
    // loop_count[108:77], loop_offset[117:109], loop_run[118], rfi_level[120:119]
    input  logic [isru_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode[2:0]
    input  logic [isru_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // new_pc[31:0], read_data[63:32]
    output logic [isru_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // pc_redirect[0], wake[1]
    output logic [isru_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import isru_pkg::*;

    isru_item_t   in_item;
    isru_item_t   item_reg;
    logic         in_valid_reg;
    logic         out_valid_reg;
    isru_result_t core_result;
    isru_result_t result_reg;
    logic         advance;

    // Unpack the request
    assign in_item.opcode      = s_axis_tuser[2:0];
    assign in_item.current_pc  = s_axis_tdata[31:0];
    assign in_item.irq_id      = s_axis_tdata[36:32];
    assign in_item.sr_index    = s_axis_tdata[44:37];
    assign in_item.write_value = s_axis_tdata[76:45];
    assign in_item.loop_count  = s_axis_tdata[108:77];
    assign in_item.loop_offset = s_axis_tdata[117:109];
    assign in_item.loop_run    = s_axis_tdata[118];
    assign in_item.rfi_level   = s_axis_tdata[120:119];

    // Step the held request when the result register is free or drains
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg <= in_item;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    isru_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .result  (core_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {result_reg.read_data, result_reg.new_pc};
    assign m_axis_tuser  = {result_reg.wake, result_reg.pc_redirect};

    // A held request is not lost or altered while the result side stalls
    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(item_reg)))
        else $error("input request dropped or changed during stall");

    // Only a special register read returns data
    a_read_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (item_reg.opcode != OP_SR_READ)) |-> (core_result.read_data == 32'd0))
        else $error("read_data nonzero for a non-read request");

    // A taken interrupt always redirects
    a_wake_redirects: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && core_result.wake) |-> core_result.pc_redirect)
        else $error("wake without pc redirect");

    // The result register is never loaded while it holds a result that is not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !advance)
        else $error("pending result overwritten");

endmodule
